>>> rtl/ola_pkg.sv
package ola_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SHOW   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_ELEMENT   = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/ola_mem.sv
module ola_mem
  import ola_pkg::*;
(
  input  logic          clk,
  input  mem_req_t      req,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ordered_list_append_remove.sv
// Ordered list of up to DEPTH (16) signed 32-bit values held in a single-port-write,
// registered-read RAM, driven by a small sequencer around one value comparator.
// An item is taken only while the sequencer is idle. Remove streams the list through
// the RAM read port, comparing one entry and moving one entry down a place per cycle.
// Show reads each entry through the registered RAM read port ahead of its result,
// or gives a single empty result when the list is empty.
// Every result passes through an output register, so a new item is taken while
// a result still waits; stalls on the result side only hold the sequencer.
// Command code 3 is taken and dropped with no result.
module ordered_list_append_remove
  import ola_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic signed [DW-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic signed [DW-1:0] out_element,
  output logic                 out_last
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RM     = 5'b00010,
    S_SH_RD  = 5'b00100,
    S_SH_OUT = 5'b01000,
    S_RES    = 5'b10000
  } state_t;

  state_t        st_r, st_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [DW-1:0] value_r, value_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          found_r, found_nxt;
  logic          pend_r, pend_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [DW-1:0] out_element_r, out_element_nxt;
  logic          out_last_r, out_last_nxt;

  mem_req_t      mem_req;
  logic [DW-1:0] mem_rdata;
  logic          out_free;
  logic          hit;
  logic [CW-1:0] rd_idx_inc;
  logic [CW-1:0] shift_idx;

  ola_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign hit        = pend_r && (mem_rdata == value_r);
  assign rd_idx_inc = rd_idx_r + CW'(1);
  assign shift_idx  = rd_idx_r - CW'(2);

  always_comb begin
    st_nxt          = st_r;
    cmd_nxt         = cmd_r;
    value_nxt       = value_r;
    count_nxt       = count_r;
    rd_idx_nxt      = rd_idx_r;
    found_nxt       = found_r;
    pend_nxt        = pend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;
    mem_req         = '0;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          value_nxt  = in_value;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          pend_nxt   = 1'b0;
          case (in_cmd)
            CMD_APPEND: st_nxt = S_RES;
            CMD_REMOVE: st_nxt = S_RM;
            CMD_SHOW:   st_nxt = (count_r == '0) ? S_RES : S_SH_RD;
            default:    st_nxt = S_IDLE;
          endcase
        end
      end
      S_RM: begin
        // entry at rd_idx-1 is in mem_rdata; later entries move down one place
        if (pend_r) begin
          if (found_r) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = shift_idx[AW-1:0];
            mem_req.wdata = mem_rdata;
          end else if (hit) begin
            found_nxt = 1'b1;
          end
        end
        if (rd_idx_r < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_idx_r[AW-1:0];
          rd_idx_nxt    = rd_idx_inc;
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            st_nxt = S_RES;
          end
        end
      end
      S_SH_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_idx_r[AW-1:0];
        st_nxt        = S_SH_OUT;
      end
      S_SH_OUT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ELEMENT;
          out_element_nxt = mem_rdata;
          out_last_nxt    = (rd_idx_inc == count_r);
          rd_idx_nxt      = rd_idx_inc;
          st_nxt          = (rd_idx_inc == count_r) ? S_IDLE : S_SH_RD;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_element_nxt = '0;
          out_last_nxt    = 1'b1;
          st_nxt          = S_IDLE;
          case (cmd_r)
            CMD_APPEND: begin
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                mem_req.we     = 1'b1;
                mem_req.waddr  = count_r[AW-1:0];
                mem_req.wdata  = value_r;
                count_nxt      = count_r + CW'(1);
              end
            end
            CMD_REMOVE: begin
              if (found_r) begin
                out_status_nxt = ST_OK;
                count_nxt      = count_r - CW'(1);
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            default: out_status_nxt = ST_EMPTY;
          endcase
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    value_r       <= value_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign in_ready    = (st_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("list count above capacity");

  a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RM && mem_req.we) |-> found_r)
    else $error("entry moved before a match");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RM) |-> (rd_idx_r <= count_r))
    else $error("remove scan past tail");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RES && cmd_r == CMD_REMOVE && out_free && found_r)
      |=> (count_r == $past(count_r) - CW'(1)))
    else $error("count not reduced after remove");

  a_show_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SH_OUT) |-> (rd_idx_r < count_r))
    else $error("show reads beyond tail");
`endif

endmodule

>>> bench/ordered_list_append_remove_tb.sv
`timescale 1ns / 100ps
module ordered_list_append_remove_tb;
  import ola_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [2:0]           status;
    logic signed [DW-1:0] element;
    logic                 last;
  } list_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_cmd = CMD_APPEND;
  logic signed [DW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_status;
  logic signed [DW-1:0] out_element;
  logic                 out_last;

  ordered_list_append_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

  // shadow copy of the list contents
  logic signed [DW-1:0] shadow_list [DEPTH];
  int                   shadow_len = 0;
  list_result_t         pending_results [$];

  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit rx_hold = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ordered_list_append_remove test failed");
    $finish;
  end

  function automatic list_result_t make_result(input logic [2:0] status,
                                               input logic signed [DW-1:0] element,
                                               input logic last);
    list_result_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    return r;
  endfunction

  task automatic apply_list_cmd(input logic [1:0] cmd, input logic signed [DW-1:0] value);
    int pos;
    pos = -1;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_len >= DEPTH) begin
          pending_results.push_back(make_result(ST_FULL, '0, 1'b1));
        end else begin
          shadow_list[shadow_len] = value;
          shadow_len++;
          pending_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      CMD_REMOVE: begin
        for (int i = 0; i < shadow_len; i++) begin
          if (pos < 0 && shadow_list[i] == value) pos = i;
        end
        if (pos < 0) begin
          pending_results.push_back(make_result(ST_NOT_FOUND, '0, 1'b1));
        end else begin
          for (int i = pos; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_len--;
          pending_results.push_back(make_result(ST_OK, '0, 1'b1));
        end
      end
      CMD_SHOW: begin
        if (shadow_len == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            pending_results.push_back(make_result(ST_ELEMENT, shadow_list[i],
                                                  (i == shadow_len - 1)));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [1:0] cmd, input logic signed [DW-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_list_cmd(cmd, value);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] pick_value(input int from_list_pct);
    int sel;
    sel = $urandom_range(99);
    if (sel < from_list_pct && shadow_len > 0) return shadow_list[$urandom_range(shadow_len - 1)];
    if (sel < from_list_pct + 35) return $signed($urandom_range(8)) - 4;
    return $urandom();
  endfunction

  task automatic send_random_item(input bit fill_bias);
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(99);
    if (r < 4) cmd = CMD_UNUSED;
    else if (r < 22) cmd = CMD_SHOW;
    else if (r < (fill_bias ? 72 : 40)) cmd = CMD_APPEND;
    else cmd = CMD_REMOVE;
    send_item(cmd, pick_value((cmd == CMD_REMOVE) ? 55 : 10));
  endtask

  task automatic test_basic_ops();
    send_item(CMD_SHOW, 32'sh1234_5678);
    send_item(CMD_REMOVE, '0);
    send_item(CMD_APPEND, 32'sh7FFF_FFFF);
    send_item(CMD_APPEND, 32'sh8000_0000);
    send_item(CMD_APPEND, '0);
    send_item(CMD_APPEND, -32'sd1);
    send_item(CMD_SHOW, '0);
    send_item(CMD_REMOVE, 32'sh8000_0000);
    send_item(CMD_REMOVE, 32'sd12345);
    send_item(CMD_UNUSED, 32'shFFFF_FFFF);
    send_item(CMD_APPEND, -32'sd1);
    // duplicate value: only the first copy goes
    send_item(CMD_REMOVE, -32'sd1);
    send_item(CMD_SHOW, 32'shFFFF_FFFF);
    wait_for_drain();
  endtask

  task automatic test_full_list();
    while (shadow_len < DEPTH) send_item(CMD_APPEND, $urandom());
    send_item(CMD_APPEND, 32'sh5555_5555);
    send_item(CMD_SHOW, '0);
    send_item(CMD_REMOVE, shadow_list[0]);
    send_item(CMD_REMOVE, shadow_list[shadow_len - 1]);
    send_item(CMD_SHOW, '0);
    wait_for_drain();
  endtask

  task automatic test_random_phase(input int n_items, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n_items; i++) send_random_item(((i / 30) % 2) == 0);
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (600) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 24; i++) send_random_item(1'b1);
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d element %0d last %0b",
                   out_status, out_element, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_element !== want.element ||
            out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d element %0d last %0b, got %0d %0d %0b",
                     want.status, want.element, want.last,
                     out_status, out_element, out_last);
        end
      end
    end
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_full_list();
    test_random_phase(100, 0, 0);
    test_random_phase(100, 88, 0);
    test_random_phase(100, 0, 88);
    test_random_phase(100, 8, 8);
    test_output_backpressure();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ordered_list_append_remove test passed");
    end else begin
      $display("ordered_list_append_remove test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ola_pkg.sv
rtl/ola_mem.sv
rtl/ordered_list_append_remove.sv
bench/ordered_list_append_remove_tb.sv
